/* hw/rtl/bdy_pkg.sv */
// ----------------------------------------------------------------------------
// bdy_pkg: buddy allocator shared definitions
// Pool sizing constants, table entry layout, status codes and helpers.
// ----------------------------------------------------------------------------
package bdy_pkg;

    localparam int MAX_POOL_ORDER = 16;
    localparam int MIN_POOL_ORDER = 9;
    localparam int HEADER_BYTES   = 16;
    localparam int UNIT_ORDER     = 5;   // log2 of the 32-byte table unit
    localparam int TABLE_DEPTH    = (1 << MAX_POOL_ORDER) / (1 << UNIT_ORDER);
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int ORDER_W        = 5;

    // Result codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic                 head;
        logic                 free;
        logic [ORDER_W-1:0]   order;
    } t_entry;

    // Smallest order k >= UNIT_ORDER with 2^k >= need
    function automatic logic [ORDER_W-1:0] fit_order(input logic [16:0] need);
        logic [ORDER_W-1:0] k;
        k = ORDER_W'(UNIT_ORDER);
        for (int i = UNIT_ORDER; i < 17; i++) begin
            if (need > (17'(1) << i)) k = ORDER_W'(i + 1);
        end
        return k;
    endfunction

endpackage

/* hw/rtl/buddy_allocator_top.sv */
// ----------------------------------------------------------------------------
// buddy_allocator_top: binary buddy allocator over a unit table memory
// Scans, splits and merges blocks held in a 2048 x 7 synchronous table.
// ----------------------------------------------------------------------------
// Allocate: one table read (S_A_RD, S_A_CHK) per block visited in the scan, then
//   one write per split level plus the final mark (S_A_SPL).
// Free: a buddy read (S_F_LOOP), then a write (S_F_BCHK), per merge level.
// Size or address-form rejects go straight to S_FIN; a refused free reads its entry first.
// Reset and every pool_order write start a clearing pass over all 2048
//   table entries during which no request is accepted.
module buddy_allocator_top
    import bdy_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_RD   = 4'd2;
    localparam logic [3:0] S_A_CHK  = 4'd3;
    localparam logic [3:0] S_A_END  = 4'd4;
    localparam logic [3:0] S_A_SPL  = 4'd5;
    localparam logic [3:0] S_F_RD   = 4'd6;
    localparam logic [3:0] S_F_CHK  = 4'd7;
    localparam logic [3:0] S_F_LOOP = 4'd8;
    localparam logic [3:0] S_F_BCHK = 4'd9;
    localparam logic [3:0] S_F_WR   = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0]         r_state;
    logic [ORDER_W-1:0] r_po;
    logic [CNT_W-1:0]   r_cnt;
    logic [ORDER_W-1:0] r_k;
    logic [ORDER_W-1:0] r_o;
    logic [ADDR_W-1:0]  r_pick;
    logic [ADDR_W-1:0]  r_u;
    logic [ADDR_W-1:0]  r_b;
    logic               r_found;
    logic [1:0]         r_frees;
    logic [1:0]         r_res;
    logic               r_out_valid;
    logic [1:0]         r_status;
    t_entry             r_rdata;

    t_entry             mem [TABLE_DEPTH];

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    t_entry             mem_wd;
    logic [ADDR_W-1:0]  mem_ra;

    logic [CNT_W-1:0]   units;
    logic [CNT_W-1:0]   blk_units;
    logic [CNT_W-1:0]   next_u;
    logic [ORDER_W-1:0] cfg_po;
    logic [15:0]        off;
    logic [16:0]        pool_bytes;
    logic               in_acc;
    logic               cfg_acc;
    logic               buddy_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign in_acc      = i_in_valid & o_in_ready;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready & ~in_acc;

    // Pool geometry
    assign units      = CNT_W'(1) << (r_po - ORDER_W'(UNIT_ORDER));
    assign pool_bytes = 17'(1) << r_po;
    assign off        = i_block_address - 16'(HEADER_BYTES);

    // Clamp the written pool order
    always_comb begin
        cfg_po = i_cfg_data;
        if (i_cfg_data < ORDER_W'(MIN_POOL_ORDER)) cfg_po = ORDER_W'(MIN_POOL_ORDER);
        if (i_cfg_data > ORDER_W'(MAX_POOL_ORDER)) cfg_po = ORDER_W'(MAX_POOL_ORDER);
    end

    // Scan step: size in units of the block seen
    always_comb begin
        if (!r_rdata.head || r_rdata.order < ORDER_W'(UNIT_ORDER) || r_rdata.order > r_po)
            blk_units = CNT_W'(1);
        else
            blk_units = CNT_W'(1) << (r_rdata.order - ORDER_W'(UNIT_ORDER));
        next_u = r_cnt + blk_units;
    end

    assign buddy_ok = r_rdata.head & r_rdata.free & (r_rdata.order == r_o);

    // Table port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_u;
        mem_wd = '0;
        mem_ra = r_cnt[ADDR_W-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                if (r_cnt == '0) mem_wd = '{head: 1'b1, free: 1'b1, order: r_po};
            end
            S_A_SPL: begin
                mem_we = 1'b1;
                if (r_o > r_k) begin
                    mem_wa = r_pick + (ADDR_W'(1) << (r_o - ORDER_W'(UNIT_ORDER + 1)));
                    mem_wd = '{head: 1'b1, free: 1'b1, order: r_o - ORDER_W'(1)};
                end else begin
                    mem_wa = r_pick;
                    mem_wd = '{head: 1'b1, free: 1'b0, order: r_o};
                end
            end
            S_F_RD: mem_ra = r_u;
            S_F_LOOP: mem_ra = r_u ^ (ADDR_W'(1) << (r_o - ORDER_W'(UNIT_ORDER)));
            S_F_BCHK: begin
                mem_we = buddy_ok;
                mem_wa = (r_b > r_u) ? r_b : r_u;
            end
            S_F_WR: begin
                mem_we = 1'b1;
                mem_wa = r_u;
                mem_wd = '{head: 1'b1, free: 1'b1, order: r_o};
            end
            default: ;
        endcase
    end

    // Unit table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_po        <= ORDER_W'(MIN_POOL_ORDER);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FIN sets or holds the result, so it never drops here
            if (r_out_valid && i_out_ready && r_state != S_FIN) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_command == CMD_ALLOC) begin
                            r_k     <= fit_order(17'(i_request_bytes) + 17'(HEADER_BYTES));
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_frees <= 2'd0;
                            if (i_request_bytes == 16'd0 || 17'(i_request_bytes) >= pool_bytes)
                            begin
                                r_res   <= ST_BAD_SIZE;
                                r_state <= S_FIN;
                            end else if (fit_order(17'(i_request_bytes) + 17'(HEADER_BYTES))
                                         > r_po) begin
                                r_res   <= ST_NO_SPACE;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_A_RD;
                            end
                        end else begin
                            r_u <= off[UNIT_ORDER +: ADDR_W];
                            if (i_block_address < 16'(HEADER_BYTES) ||
                                off[UNIT_ORDER-1:0] != '0 ||
                                CNT_W'(off[15:UNIT_ORDER]) >= units) begin
                                r_res   <= ST_BAD_ADDR;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_F_RD;
                            end
                        end
                    end else if (cfg_acc) begin
                        r_po    <= cfg_po;
                        r_cnt   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_A_RD: r_state <= S_A_CHK;
                S_A_CHK: begin
                    if (r_rdata.head && r_rdata.free) begin
                        if (r_frees != 2'd2) r_frees <= r_frees + 2'd1;
                        if (!r_found && r_rdata.order >= r_k) begin
                            r_found <= 1'b1;
                            r_pick  <= r_cnt[ADDR_W-1:0];
                            r_o     <= r_rdata.order;
                        end
                    end
                    r_cnt   <= next_u;
                    r_state <= (next_u >= units) ? S_A_END : S_A_RD;
                end
                S_A_END: begin
                    if (!r_found || (r_o == r_k && r_frees == 2'd1)) begin
                        r_res   <= ST_NO_SPACE;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_A_SPL;
                    end
                end
                S_A_SPL: begin
                    if (r_o > r_k) begin
                        r_o <= r_o - ORDER_W'(1);
                    end else begin
                        r_res   <= ST_DONE;
                        r_state <= S_FIN;
                    end
                end
                S_F_RD: r_state <= S_F_CHK;
                S_F_CHK: begin
                    r_o <= r_rdata.order;
                    if (!r_rdata.head || r_rdata.free ||
                        r_rdata.order < ORDER_W'(UNIT_ORDER) || r_rdata.order > r_po) begin
                        r_res   <= ST_BAD_ADDR;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_F_LOOP;
                    end
                end
                S_F_LOOP: begin
                    r_b     <= mem_ra;
                    r_state <= (r_o < r_po) ? S_F_BCHK : S_F_WR;
                end
                S_F_BCHK: begin
                    if (buddy_ok) begin
                        if (r_b < r_u) r_u <= r_b;
                        r_o     <= r_o + ORDER_W'(1);
                        r_state <= S_F_LOOP;
                    end else begin
                        r_state <= S_F_WR;
                    end
                end
                S_F_WR: begin
                    r_res   <= ST_DONE;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/bdy_checker.sv */
// ----------------------------------------------------------------------------
// bdy_checker: port-level checks for the buddy allocator
// Watches handshakes and result timing on the top level ports.
// ----------------------------------------------------------------------------
module bdy_checker
    import bdy_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_command,
    input logic [15:0] i_request_bytes,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);

    // A stalled result holds its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");

    // One transaction at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while busy");

    // A config write starts the clearing pass
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && !i_in_valid |=> !o_in_ready && !o_cfg_ready)
        else $error("no clearing pass after config write");

    // A zero-byte allocate is rejected as a bad size
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_command == CMD_ALLOC && i_request_bytes == 16'd0
        && (!o_out_valid || i_out_ready)
        |=> ##1 o_out_valid && o_status == ST_BAD_SIZE)
        else $error("zero-byte allocate not rejected");

endmodule

bind buddy_allocator_top bdy_checker u_bdy_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_command       (i_command),
    .i_request_bytes (i_request_bytes),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready)
);

/* sim/bdy_alloc_checker.sv */
// ----------------------------------------------------------------------------
// bdy_alloc_checker: status predictor and scoreboard for the buddy allocator
// Watches the request, status and configuration channels. It keeps its own
// copy of the unit table and predicts a status for every request transaction.
// Each status transaction is then compared with the oldest prediction.
// ----------------------------------------------------------------------------
module bdy_alloc_checker
    import bdy_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_entry     unit_tbl [TABLE_DEPTH];
    int         pool_ord;
    int         low_free;
    logic [1:0] status_q [$];
    int         n_err;

    assign o_errors  = n_err;
    assign o_pending = status_q.size();

    function automatic int blk_units(t_entry e, int po);
        if (!e.head || e.order < UNIT_ORDER || e.order > po) return 1;
        return 1 << (e.order - UNIT_ORDER);
    endfunction

    task automatic reinit_pool();
        foreach (unit_tbl[i]) unit_tbl[i] = '0;
        unit_tbl[0] = '{head: 1'b1, free: 1'b1, order: ORDER_W'(pool_ord)};
        low_free = 0;
    endtask

    task automatic rescan_low_free();
        int u;
        u = 0;
        low_free = 0;
        while (u < (1 << (pool_ord - UNIT_ORDER))) begin
            if (unit_tbl[u].head && unit_tbl[u].free) begin
                low_free = u;
                return;
            end
            u += blk_units(unit_tbl[u], pool_ord);
        end
    endtask

    task automatic model_alloc(input int n, output logic [1:0] st);
        int units, k, u, frees, pick, o;
        bit found;
        units = 1 << (pool_ord - UNIT_ORDER);
        k = UNIT_ORDER;
        u = 0;
        frees = 0;
        pick = 0;
        found = 0;
        if (n == 0 || n >= (1 << pool_ord)) begin
            st = ST_BAD_SIZE;
            return;
        end
        while ((1 << k) < n + HEADER_BYTES) k++;
        if (k > pool_ord) begin
            st = ST_NO_SPACE;
            return;
        end
        // first fit scan, counting free blocks on the way
        while (u < units) begin
            if (unit_tbl[u].head && unit_tbl[u].free) begin
                frees++;
                if (!found && unit_tbl[u].order >= k) begin
                    found = 1;
                    pick = u;
                end
            end
            u += blk_units(unit_tbl[u], pool_ord);
        end
        if (!found) begin
            st = ST_NO_SPACE;
            return;
        end
        o = unit_tbl[pick].order;
        // refuse to hand out the very last free block whole
        if (o == k && frees == 1) begin
            st = ST_NO_SPACE;
            return;
        end
        while (o > k) begin
            o--;
            unit_tbl[pick + (1 << (o - UNIT_ORDER))] =
                '{head: 1'b1, free: 1'b1, order: ORDER_W'(o)};
        end
        unit_tbl[pick] = '{head: 1'b1, free: 1'b0, order: ORDER_W'(o)};
        rescan_low_free();
        st = ST_DONE;
    endtask

    task automatic model_free(input int addr, output logic [1:0] st);
        int units, off, u, o, sz, bud;
        units = 1 << (pool_ord - UNIT_ORDER);
        st = ST_BAD_ADDR;
        if (addr < HEADER_BYTES) return;
        off = addr - HEADER_BYTES;
        if ((off & ((1 << UNIT_ORDER) - 1)) != 0) return;
        u = off >> UNIT_ORDER;
        if (u >= units) return;
        if (!unit_tbl[u].head || unit_tbl[u].free) return;
        o = unit_tbl[u].order;
        if (o < UNIT_ORDER || o > pool_ord) return;
        // merge upward while the buddy is a whole free block of equal size
        while (o < pool_ord) begin
            sz = 1 << (o - UNIT_ORDER);
            bud = u ^ sz;
            if (bud >= units) break;
            if (!unit_tbl[bud].head || !unit_tbl[bud].free ||
                unit_tbl[bud].order != o) break;
            unit_tbl[u] = '0;
            unit_tbl[bud] = '0;
            if (bud < u) u = bud;
            o++;
        end
        unit_tbl[u] = '{head: 1'b1, free: 1'b1, order: ORDER_W'(o)};
        rescan_low_free();
        st = ST_DONE;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t bdy_alloc_checker: %s", $realtime, what);
        n_err++;
    endtask

    initial n_err = 0;

    // scoreboard: compare first, then predict the new transaction
    always @(posedge i_clk) begin
        logic [1:0] exp_st;
        logic [1:0] pred;
        int v;
        if (!i_rst_n) begin
            pool_ord = MIN_POOL_ORDER;
            reinit_pool();
            status_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("status %0d with none expected", i_status));
                end else begin
                    exp_st = status_q.pop_front();
                    if (i_status !== exp_st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, exp_st));
                end
            end
            // a request transaction takes priority over a config write
            if (i_cfg_valid && i_cfg_ready && !(i_in_valid && i_in_ready)) begin
                v = i_cfg_data;
                if (v < MIN_POOL_ORDER) v = MIN_POOL_ORDER;
                if (v > MAX_POOL_ORDER) v = MAX_POOL_ORDER;
                pool_ord = v;
                reinit_pool();
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_ALLOC) model_alloc(i_request_bytes, pred);
                else model_free(i_block_address, pred);
                status_q.push_back(pred);
            end
        end
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: buddy allocator testbench
// Drives allocate and free transactions with random gaps and status stalls
// over several pool sizes; the checker predicts and compares every status.
// ----------------------------------------------------------------------------
module tb_top;
    import bdy_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 10000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_ALLOC;
    logic [15:0] request_bytes = '0;
    logic [15:0] block_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    int          errors;
    int          pending;
    int          cur_order = MIN_POOL_ORDER;
    int          cycles = 0;

    always #2 i_clk = ~i_clk;

    buddy_allocator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (command),
        .i_request_bytes (request_bytes),
        .i_block_address (block_address),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    bdy_alloc_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_command       (command),
        .i_request_bytes (request_bytes),
        .i_block_address (block_address),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_status        (status),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // status side: random stall before each transaction
    initial begin
        int d;
        @(posedge i_clk iff i_rst_n);
        forever begin
            d = $urandom_range(0, 9);
            if (d > 0) begin
                out_ready <= 1'b0;
                repeat (d) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    task automatic put_request(input logic cmd, input logic [15:0] nbytes,
                               input logic [15:0] addr);
        int d;
        d = $urandom_range(0, 9);
        if (d > 0) begin
            in_valid <= 1'b0;
            repeat (d) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        request_bytes <= nbytes;
        block_address <= addr;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // only while idle: all statuses back, then a short settle
    task automatic write_pool_order(input logic [4:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cur_order = (val < MIN_POOL_ORDER) ? MIN_POOL_ORDER :
                    (val > MAX_POOL_ORDER) ? MAX_POOL_ORDER : int'(val);
    endtask

    task automatic random_request();
        int r, pool, u, j;
        pool = 1 << cur_order;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            r = $urandom_range(0, 9);
            if (r < 7) put_request(CMD_ALLOC, 16'($urandom_range(1, pool >> 2)), '0);
            else if (r < 9) put_request(CMD_ALLOC, 16'($urandom_range(1, pool - 17)), '0);
            else put_request(CMD_ALLOC, 16'($urandom()), 16'($urandom()));
        end else begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                j = $urandom_range(0, 3);
                u = ($urandom_range(0, (pool >> 5) - 1) >> j) << j;
                put_request(CMD_FREE, 16'($urandom()), 16'(HEADER_BYTES + 32 * u));
            end else begin
                put_request(CMD_FREE, 16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    initial begin
        logic [4:0] orders [8];
        int t;
        orders = '{5'd16, 5'd12, 5'd31, 5'd10, 5'd0, 5'd11, 5'd9, 5'd14};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: size limits, last-block refusal, bad addresses, merges
        put_request(CMD_ALLOC, 16'd0, '0);
        put_request(CMD_ALLOC, 16'hFFFF, '0);
        put_request(CMD_ALLOC, 16'd512, '0);
        put_request(CMD_ALLOC, 16'd496, '0);
        put_request(CMD_ALLOC, 16'd497, '0);
        put_request(CMD_ALLOC, 16'd1, '0);
        put_request(CMD_ALLOC, 16'd16, '0);
        put_request(CMD_ALLOC, 16'd17, '0);
        put_request(CMD_ALLOC, 16'd200, '0);
        put_request(CMD_FREE, '0, 16'd0);
        put_request(CMD_FREE, '0, 16'd15);
        put_request(CMD_FREE, '0, 16'd17);
        put_request(CMD_FREE, '0, 16'hFFFF);
        put_request(CMD_FREE, '0, 16'd528);
        put_request(CMD_FREE, '0, 16'd48);
        put_request(CMD_FREE, '0, 16'd48);
        put_request(CMD_FREE, '0, 16'd16);
        put_request(CMD_FREE, '0, 16'd80);
        put_request(CMD_FREE, '0, 16'd272);
        put_request(CMD_ALLOC, 16'd240, '0);
        put_request(CMD_ALLOC, 16'd240, '0);

        for (int p = 0; p < 8; p++) begin
            write_pool_order(orders[p]);
            t = (orders[p] == 5'd16) ? 60 : 100;
            for (int i = 0; i < t; i++) random_request();
        end
        write_pool_order(5'($urandom_range(0, 31)));
        for (int i = 0; i < 60; i++) random_request();

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bdy_pkg.sv
hw/rtl/buddy_allocator_top.sv
hw/rtl/bdy_checker.sv
sim/bdy_alloc_checker.sv
sim/tb_top.sv
